### hw/rtl/cts_pkg.sv
// shared constants and types for the cubic trajectory sampler
package cts_pkg;

  // sample count is a power of two, so every divide by it is a shift
  localparam int SAMPLE_SHIFT = 10;
  localparam int SAMPLE_COUNT = 1 << SAMPLE_SHIFT;
  localparam int INDEX_W      = SAMPLE_SHIFT;
  localparam int DATA_W       = 32;
  localparam int NUM_W        = 96;
  localparam int CFG_INDEX_W  = 3;

  // position divides by 2^16 * N^3, velocity by duration * N^2
  localparam int POS_SHIFT = 16 + 3 * SAMPLE_SHIFT;
  localparam int VEL_SHIFT = 2 * SAMPLE_SHIFT;

  localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_VELOCITY = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_END_POSITION   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_END_VELOCITY   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DURATION       = 3'd4;

  localparam logic [DATA_W-1:0] RESET_END_POSITION = 32'd655360;
  localparam logic [DATA_W-1:0] RESET_DURATION     = 32'd196608;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // one word of the velocity divider, with the results that ride along
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic              neg;
    logic              ovf;
    logic [DATA_W-1:0] sample_time;
    logic [DATA_W-1:0] position;
  } div_word_t;

endpackage

### hw/rtl/cts_channels.sv
// request and result channels of the cubic trajectory sampler
interface cts_sample_if;
  logic                        valid;
  logic                        ready;
  logic [cts_pkg::INDEX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink (input valid, input sample_index, output ready);
endinterface

interface cts_point_if;
  logic                              valid;
  logic                              ready;
  logic [cts_pkg::DATA_W-1:0]        sample_time;
  logic signed [cts_pkg::DATA_W-1:0] position;
  logic signed [cts_pkg::DATA_W-1:0] velocity;
  logic                              bad_duration;

  modport source (output valid, output sample_time, output position, output velocity,
                  output bad_duration, input ready);
  modport sink (input valid, input sample_time, input position, input velocity,
                input bad_duration, output ready);
endinterface

### hw/rtl/cts_vel_div.sv
// pipelined restoring divider for the velocity quotient, one bit per stage
module cts_vel_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [cts_pkg::DATA_W-1:0] divisor,
  input  logic                       in_valid,
  input  cts_pkg::div_word_t         in_word,
  output logic                       out_valid,
  output cts_pkg::div_word_t         out_word
);

  localparam int STEPS = cts_pkg::DATA_W;

  logic [STEPS-1:0]   valid;
  cts_pkg::div_word_t word [STEPS];
  cts_pkg::div_word_t step [STEPS];

  always_comb begin
    cts_pkg::div_word_t      cur;
    logic [STEPS:0]          trial;
    logic                    fits;
    for (int j = 0; j < STEPS; j++) begin
      cur = (j == 0) ? in_word : word[(j == 0) ? 0 : j - 1];
      // next dividend bit comes off the top of the quotient word
      trial = {cur.rem, cur.quo[STEPS-1]};
      fits  = trial >= {1'b0, divisor};
      step[j]     = cur;
      step[j].rem = fits ? STEPS'(trial - {1'b0, divisor}) : trial[STEPS-1:0];
      step[j].quo = {cur.quo[STEPS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[STEPS-2:0], in_valid};
    end
    if (en) begin
      for (int j = 0; j < STEPS; j++) begin
        word[j] <= step[j];
      end
    end
  end

  assign out_valid = valid[STEPS-1];
  assign out_word  = word[STEPS-1];

endmodule

### hw/rtl/cubic_trajectory_sampler.sv
// cubic hermite trajectory sampler: time, position and velocity for each sample index
// results leave in request order; one request per cycle sustained while points.ready is high
// the depth is set by the 32-stage velocity divider behind the ten request and arithmetic stages
// a stalled result holds the pipeline, but the first stage still takes a request if empty
// synchronous reset clears the stage valid bits and loads the register reset values
module cubic_trajectory_sampler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cts_pkg::DATA_W-1:0]      cfg_data,
  cts_sample_if.sink                      samples,
  cts_point_if.source                     points
);

  localparam int DW = cts_pkg::DATA_W;
  localparam int NW = cts_pkg::NUM_W;
  localparam int SH = cts_pkg::SAMPLE_SHIFT;
  localparam int KW = cts_pkg::INDEX_W;
  localparam int PQ_W = NW - cts_pkg::POS_SHIFT;
  localparam int VH_W = NW - cts_pkg::VEL_SHIFT - DW;

  // configuration
  logic [DW-1:0] start_position;
  logic [DW-1:0] start_velocity;
  logic [DW-1:0] end_position;
  logic [DW-1:0] end_velocity;
  logic [DW-1:0] duration;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
      start_velocity <= '0;
      end_position   <= cts_pkg::RESET_END_POSITION;
      end_velocity   <= '0;
      duration       <= cts_pkg::RESET_DURATION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cts_pkg::REG_START_POSITION: start_position <= cfg_data;
        cts_pkg::REG_START_VELOCITY: start_velocity <= cfg_data;
        cts_pkg::REG_END_POSITION:   end_position   <= cfg_data;
        cts_pkg::REG_END_VELOCITY:   end_velocity   <= cfg_data;
        cts_pkg::REG_DURATION:       duration       <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic        adv;
  logic        load1;
  logic [10:1] stage_valid;
  logic        div_valid;
  logic        out_valid;

  assign adv           = !out_valid || points.ready;
  assign load1         = adv || !stage_valid[1];
  assign samples.ready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (load1) begin
        stage_valid[1] <= samples.valid;
      end
      if (adv) begin
        stage_valid[10:2] <= stage_valid[9:1];
      end
    end
  end

  // stage 1: request register
  logic [KW-1:0] k1;

  always_ff @(posedge clk) begin
    if (load1) begin
      k1 <= samples.sample_index;
    end
  end

  // stage 2: k squared and sample time
  logic [KW-1:0]      k2;
  logic [2*KW-1:0]    ksq2;
  logic [DW-1:0]      time2;
  logic [DW+KW-1:0]   time_prod;

  assign time_prod = (DW + KW)'(k1) * (DW + KW)'(duration);

  always_ff @(posedge clk) begin
    if (adv) begin
      k2    <= k1;
      ksq2  <= (2 * KW)'(k1) * (2 * KW)'(k1);
      time2 <= time_prod[SH +: DW];
    end
  end

  // stage 3: k cubed
  logic [KW-1:0]   k3;
  logic [2*KW-1:0] ksq3;
  logic [3*KW-1:0] kcube3;
  logic [DW-1:0]   time3;

  always_ff @(posedge clk) begin
    if (adv) begin
      k3     <= k2;
      ksq3   <= ksq2;
      kcube3 <= (3 * KW)'(ksq2) * (3 * KW)'(k2);
      time3  <= time2;
    end
  end

  // stage 4: hermite coefficients scaled by N^3 (position) and N^2 (velocity)
  localparam int CW = 34;

  logic [CW-1:0] k_e, ksq_e, kcube_e;
  logic [CW-1:0] c00_w, c01_w, c10_w, c11_w;
  logic [CW-1:0] d00_w, d01_w, d10_w, d11_w;

  always_comb begin
    k_e     = CW'(k3);
    ksq_e   = CW'(ksq3);
    kcube_e = CW'(kcube3);
    c01_w = (ksq_e << (SH + 1)) + (ksq_e << SH) - (kcube_e << 1);
    c00_w = (CW'(1) << (3 * SH)) - c01_w;
    c10_w = kcube_e + (k_e << (2 * SH)) - (ksq_e << (SH + 1));
    c11_w = kcube_e - (ksq_e << SH);
    d00_w = (ksq_e << 2) + (ksq_e << 1) - (k_e << (SH + 2)) - (k_e << (SH + 1));
    d01_w = CW'(0) - d00_w;
    d10_w = (ksq_e << 1) + ksq_e - (k_e << (SH + 2)) + (CW'(1) << (2 * SH));
    d11_w = (ksq_e << 1) + ksq_e - (k_e << (SH + 1));
  end

  logic signed [31:0] c00, c01, c10, c11;
  logic signed [23:0] d00, d01, d10, d11;
  logic [DW-1:0]      time4;

  always_ff @(posedge clk) begin
    if (adv) begin
      c00   <= c00_w[31:0];
      c01   <= c01_w[31:0];
      c10   <= c10_w[31:0];
      c11   <= c11_w[31:0];
      d00   <= d00_w[23:0];
      d01   <= d01_w[23:0];
      d10   <= d10_w[23:0];
      d11   <= d11_w[23:0];
      time4 <= time3;
    end
  end

  // stage 5: register times coefficient
  logic signed [63:0] pa5, pb5, pc5, pd5;
  logic signed [55:0] va5, vb5, vc5, vd5;
  logic [DW-1:0]      time5;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa5   <= 64'($signed(start_position)) * 64'(c00);
      pb5   <= 64'($signed(end_position)) * 64'(c01);
      pc5   <= 64'($signed(start_velocity)) * 64'(c10);
      pd5   <= 64'($signed(end_velocity)) * 64'(c11);
      va5   <= 56'($signed(start_position)) * 56'(d00);
      vb5   <= 56'($signed(end_position)) * 56'(d01);
      vc5   <= 56'($signed(start_velocity)) * 56'(d10);
      vd5   <= 56'($signed(end_velocity)) * 56'(d11);
      time5 <= time4;
    end
  end

  // stage 6: position-term and velocity-term sums
  logic signed [64:0] pos_p6, pos_v6;
  logic signed [56:0] vel_p6, vel_v6;
  logic [DW-1:0]      time6;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_p6 <= 65'(pa5) + 65'(pb5);
      pos_v6 <= 65'(pc5) + 65'(pd5);
      vel_p6 <= 57'(va5) + 57'(vb5);
      vel_v6 <= 57'(vc5) + 57'(vd5);
      time6  <= time5;
    end
  end

  // stage 7: velocity-term sums times duration, split into the low 32 bits and the upper part
  logic signed [64:0] pos_p7;
  logic [63:0]        pos_lo7;
  logic signed [65:0] pos_hi7;
  logic signed [56:0] vel_p7;
  logic [63:0]        vel_lo7;
  logic signed [57:0] vel_hi7;
  logic [DW-1:0]      time7;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_p7  <= pos_p6;
      pos_lo7 <= 64'(pos_v6[31:0]) * 64'(duration);
      pos_hi7 <= 66'($signed(pos_v6[64:32])) * 66'($signed({1'b0, duration}));
      vel_p7  <= vel_p6;
      vel_lo7 <= 64'(vel_v6[31:0]) * 64'(duration);
      vel_hi7 <= 58'($signed(vel_v6[56:32])) * 58'($signed({1'b0, duration}));
      time7   <= time6;
    end
  end

  // stage 8: full numerators
  logic [NW-1:0] pos_num8, vel_num8;
  logic [DW-1:0] time8;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_num8 <= (NW'(pos_p7) << 16) + (NW'(pos_hi7) << 32) + NW'(pos_lo7);
      vel_num8 <= (NW'(vel_p7) << 16) + (NW'(vel_hi7) << 32) + NW'(vel_lo7);
      time8    <= time7;
    end
  end

  // stage 9: sign and magnitude, rounding is toward zero
  logic [NW-1:0] pos_mag9, vel_mag9;
  logic          pos_neg9, vel_neg9;
  logic [DW-1:0] time9;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_neg9 <= pos_num8[NW-1];
      vel_neg9 <= vel_num8[NW-1];
      pos_mag9 <= pos_num8[NW-1] ? NW'(0) - pos_num8 : pos_num8;
      vel_mag9 <= vel_num8[NW-1] ? NW'(0) - vel_num8 : vel_num8;
      time9    <= time8;
    end
  end

  // stage 10: position quotient is a shift; velocity set up for the divider
  logic [PQ_W-1:0]    pos_q;
  logic               pos_sat;
  logic [DW-1:0]      pos_val;
  logic [VH_W-1:0]    vel_hi;
  cts_pkg::div_word_t div_in;
  cts_pkg::div_word_t div_in_next;

  always_comb begin
    pos_q   = pos_mag9[NW-1:cts_pkg::POS_SHIFT];
    pos_sat = |pos_q[PQ_W-1:DW-1];
    if (pos_sat) begin
      pos_val = pos_neg9 ? cts_pkg::SAT_MIN : cts_pkg::SAT_MAX;
    end else begin
      pos_val = pos_neg9 ? DW'(0) - pos_q[DW-1:0] : pos_q[DW-1:0];
    end
    vel_hi                  = vel_mag9[NW-1:cts_pkg::VEL_SHIFT+DW];
    // quotient needs more than 32 bits once the top part reaches the divisor
    div_in_next.ovf         = vel_hi >= VH_W'(duration);
    div_in_next.rem         = vel_hi[DW-1:0];
    div_in_next.quo         = vel_mag9[cts_pkg::VEL_SHIFT +: DW];
    div_in_next.neg         = vel_neg9;
    div_in_next.sample_time = time9;
    div_in_next.position    = pos_val;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_in <= div_in_next;
    end
  end

  cts_pkg::div_word_t div_out;

  cts_vel_div u_vel_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .divisor   (duration),
    .in_valid  (stage_valid[10]),
    .in_word   (div_in),
    .out_valid (div_valid),
    .out_word  (div_out)
  );

  // result register
  logic [DW-1:0] vel_val;
  logic          vel_sat;
  logic          bad;
  logic [DW-1:0] sample_time;
  logic [DW-1:0] position;
  logic [DW-1:0] velocity;
  logic          bad_duration;

  always_comb begin
    vel_sat = div_out.ovf || div_out.quo[DW-1];
    if (vel_sat) begin
      vel_val = div_out.neg ? cts_pkg::SAT_MIN : cts_pkg::SAT_MAX;
    end else begin
      vel_val = div_out.neg ? DW'(0) - div_out.quo : div_out.quo;
    end
    bad = duration == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_valid;
    end
    if (adv && div_valid) begin
      bad_duration <= bad;
      sample_time  <= bad ? '0 : div_out.sample_time;
      position     <= bad ? start_position : div_out.position;
      velocity     <= bad ? '0 : vel_val;
    end
  end

  assign points.valid        = out_valid;
  assign points.sample_time  = sample_time;
  assign points.position     = position;
  assign points.velocity     = velocity;
  assign points.bad_duration = bad_duration;

endmodule

### test/cubic_trajectory_sampler_tb.sv
// self-checking testbench for the cubic trajectory sampler, with its own exact predictor
module cubic_trajectory_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::*;

  typedef struct {
    logic [DATA_W-1:0]        sample_time;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
    logic                     bad_duration;
  } point_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DATA_W-1:0]      cfg_data;

  cts_sample_if samples();
  cts_point_if  points();

  cubic_trajectory_sampler uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .points    (points)
  );

  // move settings as the block should hold them
  logic signed [DATA_W-1:0] move_start_pos;
  logic signed [DATA_W-1:0] move_start_vel;
  logic signed [DATA_W-1:0] move_end_pos;
  logic signed [DATA_W-1:0] move_end_vel;
  logic [DATA_W-1:0]        move_duration;

  point_t expected_points[$];
  int     mismatch_count;
  int     requests_sent;
  int     results_checked;
  int     settings_count;
  int     zero_duration_count;
  bit     steady_flow;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] saturate(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return SAT_MAX;
    if (v < -128'sd2147483648) return SAT_MIN;
    return v[DATA_W-1:0];
  endfunction

  // exact hermite evaluation at t = k*T/N, one truncation toward zero at the end
  function automatic point_t hermite_point(input logic [INDEX_W-1:0] k_in);
    point_t              pt;
    logic signed [127:0] k, n, k2, k3, n2, n3, p0, p1, v0, v1, tr, num;
    logic [63:0]         t;
    k  = k_in;
    n  = SAMPLE_COUNT;
    k2 = k * k;
    k3 = k2 * k;
    n2 = n * n;
    n3 = n2 * n;
    p0 = move_start_pos;
    p1 = move_end_pos;
    v0 = move_start_vel;
    v1 = move_end_vel;
    tr = move_duration;
    pt.bad_duration = (move_duration == '0);
    if (pt.bad_duration) begin
      pt.sample_time = '0;
      pt.position    = move_start_pos;
      pt.velocity    = '0;
      return pt;
    end
    t = (64'(k_in) * 64'(move_duration)) / SAMPLE_COUNT;
    pt.sample_time = (t > 64'h0000_0000_FFFF_FFFF) ? '1 : t[DATA_W-1:0];
    num = ((p0 * (2 * k3 - 3 * k2 * n + n3) + p1 * (3 * k2 * n - 2 * k3)) <<< 16)
        + tr * (v0 * (k3 - 2 * k2 * n + k * n2) + v1 * (k3 - k2 * n));
    pt.position = saturate(num / ((n3 <<< 16)));
    num = ((p0 * (6 * k2 - 6 * k * n) + p1 * (6 * k * n - 6 * k2)) <<< 16)
        + tr * (v0 * (3 * k2 - 4 * k * n + n2) + v1 * (3 * k2 - 2 * k * n));
    pt.velocity = saturate(num / (tr * n2));
    return pt;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got, input int seq);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s expected %h got %h", seq, name, want, got));
  endtask

  // result side: random back-pressure, then free flow at the end of the run
  initial begin
    points.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!steady_flow && $urandom_range(0, 3) == 0) begin
        points.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      points.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_checker
    point_t want;
    if (rst === 1'b0 && points.valid === 1'b1 && points.ready === 1'b1) begin
      if (expected_points.size() == 0) begin
        flag_mismatch($sformatf("result with no request waiting: time %h pos %h vel %h",
                                points.sample_time, points.position, points.velocity));
      end else begin
        want = expected_points.pop_front();
        check_field("sample_time", want.sample_time, points.sample_time, results_checked);
        check_field("position", want.position, points.position, results_checked);
        check_field("velocity", want.velocity, points.velocity, results_checked);
        check_field("bad_duration", 32'(want.bad_duration), 32'(points.bad_duration),
                    results_checked);
      end
      results_checked++;
    end
  end

  task automatic send_sample(input logic [INDEX_W-1:0] k);
    if (!steady_flow && $urandom_range(0, 5) == 0) begin
      samples.valid        <= 1'b0;
      samples.sample_index <= INDEX_W'($urandom);
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    samples.valid        <= 1'b1;
    samples.sample_index <= k;
    @(posedge clk);
    while (samples.ready !== 1'b1) @(posedge clk);
    expected_points.push_back(hermite_point(k));
    requests_sent++;
  endtask

  // stop requesting and let every outstanding result come back
  task automatic drain_pipeline();
    samples.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_START_POSITION: move_start_pos = value;
      REG_START_VELOCITY: move_start_vel = value;
      REG_END_POSITION:   move_end_pos   = value;
      REG_END_VELOCITY:   move_end_vel   = value;
      REG_DURATION:       move_duration  = value;
      default: ;
    endcase
  endtask

  task automatic program_move(input logic [DATA_W-1:0] p0, input logic [DATA_W-1:0] v0,
                              input logic [DATA_W-1:0] p1, input logic [DATA_W-1:0] v1,
                              input logic [DATA_W-1:0] dur);
    drain_pipeline();
    write_register(REG_START_POSITION, p0);
    write_register(REG_START_VELOCITY, v0);
    write_register(REG_END_POSITION, p1);
    write_register(REG_END_VELOCITY, v1);
    write_register(REG_DURATION, dur);
    cfg_we <= 1'b0;
    settings_count++;
    if (dur == '0) zero_duration_count++;
  endtask

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 1 << 23) - (1 << 22);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_duration();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3, 4, 5: return $urandom;
      default: return $urandom_range(6554, 1310720);
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] random_index();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return INDEX_W'(SAMPLE_COUNT / 2);
      default: return INDEX_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_values();
    send_sample('0);
    send_sample(INDEX_W'(1));
    send_sample(INDEX_W'(2));
    send_sample(INDEX_W'(SAMPLE_COUNT / 2 - 1));
    send_sample(INDEX_W'(SAMPLE_COUNT / 2));
    send_sample('1);
  endtask

  // full-scale settings push position and velocity into saturation
  task automatic test_extreme_moves();
    program_move(SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN, '1);
    send_sample('0);
    send_sample(INDEX_W'(SAMPLE_COUNT / 2));
    send_sample('1);
    program_move(SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX, '1);
    send_sample(INDEX_W'(1));
    send_sample(INDEX_W'(SAMPLE_COUNT / 4));
    send_sample('1);
    // one-lsb duration makes every velocity huge
    program_move('0, SAT_MAX, 32'd655360, SAT_MIN, 32'd1);
    send_sample('0);
    send_sample(INDEX_W'(SAMPLE_COUNT / 2));
    send_sample('1);
  endtask

  task automatic test_zero_duration();
    program_move($urandom, $urandom, $urandom, $urandom, '0);
    send_sample('0);
    send_sample(INDEX_W'(300));
    send_sample('1);
  endtask

  // writes above the last register must leave the move untouched
  task automatic test_ignored_registers();
    program_move(32'd65536, 32'hFFFF_0000, 32'd327680, 32'd32768, 32'd131072);
    for (int i = REG_DURATION + 1; i < (1 << CFG_INDEX_W); i++)
      write_register(CFG_INDEX_W'(i), $urandom);
    cfg_we <= 1'b0;
    send_sample(INDEX_W'(100));
    send_sample(INDEX_W'(700));
    send_sample('1);
  endtask

  task automatic test_random_moves(input int phases, input int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      program_move(random_word(), random_word(), random_word(), random_word(),
                   random_duration());
      repeat (per_phase) send_sample(random_index());
    end
  endtask

  initial begin : run
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    samples.valid        <= 1'b0;
    samples.sample_index <= '0;
    move_start_pos       = '0;
    move_start_vel       = '0;
    move_end_pos         = RESET_END_POSITION;
    move_end_vel         = '0;
    move_duration        = RESET_DURATION;
    mismatch_count       = 0;
    requests_sent        = 0;
    results_checked      = 0;
    settings_count       = 1;
    zero_duration_count  = 0;
    steady_flow          = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_extreme_moves();
    test_zero_duration();
    test_ignored_registers();
    test_random_moves(12, 45);
    steady_flow = 1'b1;
    test_random_moves(2, 45);

    drain_pipeline();
    repeat (50) @(posedge clk);
    if (expected_points.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_points.size()));
    $display("covered %0d requests over %0d move settings (%0d with zero duration)",
             requests_sent, settings_count, zero_duration_count);
    $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
